// ----- sv/sfm_pkg.sv -----
// Shared types and constants for the safety fault monitor.
// No dependencies; every other file but sfm_if.sv imports this package.
`default_nettype none

package sfm_pkg;

   // One tick beat on the request side
   typedef struct packed {
      logic       overcurrent;
      logic       overtemp;
      logic       dir_err;
      logic       stall_err;
      logic       batt_err;
      logic       self_test_failed;
      logic       estop;
      logic       vehicle_shutdown;
      logic [1:0] can_state;
      logic       can_rx_seen;
   } sfm_req_type;

   // One result beat on the response side
   typedef struct packed {
      logic [7:0] flt_bits;
      logic [1:0] status_code;
      logic       motor_disable;
      logic       wdi_level;
      logic       wdg_fail_report;
   } sfm_rsp_type;

   // Handshake between the input register and the core
   typedef struct packed {
      logic        valid;
      sfm_req_type data;
   } sfm_stage_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W       = 1;
   localparam int unsigned CSR_DATA_W        = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARNING_LIMIT = 1'b1;

   // Reset values of the limits
   localparam logic [7:0]  SILENCE_LIMIT_RST = 8'd20;
   localparam logic [15:0] WARNING_LIMIT_RST = 16'd50;

   // CAN controller states
   localparam logic [1:0] CAN_ST_WARNING = 2'd1;
   localparam logic [1:0] CAN_ST_BUSOFF  = 2'd2;

   // Safety status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DEGRADED = 2'd1;
   localparam logic [1:0] STATUS_FAULT    = 2'd2;

   // Fault mask bit positions
   localparam int unsigned FM_OVERCURRENT = 0;
   localparam int unsigned FM_OVERTEMP    = 1;
   localparam int unsigned FM_DIRECTION   = 2;
   localparam int unsigned FM_STALL       = 3;
   localparam int unsigned FM_BATTERY     = 4;
   localparam int unsigned FM_SELFTEST    = 5;
   localparam int unsigned FM_CAN         = 6;
   localparam int unsigned FM_WATCHDOG    = 7;

   localparam logic [7:0] FM_CRITICAL = 8'h47;

endpackage : sfm_pkg

`default_nettype wire

// ----- sv/sfm_if.sv -----
// Valid/ready channel interfaces for the request and response beats.
// No dependencies.
`default_nettype none

interface sfm_req_if;
   logic       valid;
   logic       ready;
   logic       overcurrent;
   logic       overtemp;
   logic       dir_err;
   logic       stall_err;
   logic       batt_err;
   logic       self_test_failed;
   logic       estop;
   logic       vehicle_shutdown;
   logic [1:0] can_state;
   logic       can_rx_seen;

   modport source (
      output valid, overcurrent, overtemp, dir_err, stall_err, batt_err,
             self_test_failed, estop, vehicle_shutdown, can_state,
             can_rx_seen,
      input  ready
   );
   modport sink (
      input  valid, overcurrent, overtemp, dir_err, stall_err, batt_err,
             self_test_failed, estop, vehicle_shutdown, can_state,
             can_rx_seen,
      output ready
   );
endinterface : sfm_req_if

interface sfm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] flt_bits;
   logic [1:0] status_code;
   logic       motor_disable;
   logic       wdi_level;
   logic       wdg_fail_report;

   modport source (
      output valid, flt_bits, status_code, motor_disable, wdi_level, wdg_fail_report,
      input  ready
   );
   modport sink (
      input  valid, flt_bits, status_code, motor_disable, wdi_level, wdg_fail_report,
      output ready
   );
endinterface : sfm_rsp_if

`default_nettype wire

// ----- sv/sfm_in_reg.sv -----
// Input register: captures one tick beat from the request channel.
// Depends on sfm_pkg and sfm_req_if.
`default_nettype none

module sfm_in_reg
   import sfm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   sfm_req_if.sink      req,
   output sfm_stage_type stage,
   input  wire logic    stage_take
);

   logic        valid_ff;
   logic        valid_in;
   sfm_req_type data_ff;
   logic        accept;

   // free slot, or the held beat leaves this cycle
   assign req.ready = !valid_ff || stage_take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= '{
            overcurrent:      req.overcurrent,
            overtemp:         req.overtemp,
            dir_err:          req.dir_err,
            stall_err:        req.stall_err,
            batt_err:         req.batt_err,
            self_test_failed: req.self_test_failed,
            estop:            req.estop,
            vehicle_shutdown: req.vehicle_shutdown,
            can_state:        req.can_state,
            can_rx_seen:      req.can_rx_seen
         };
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule : sfm_in_reg

`default_nettype wire

// ----- sv/sfm_core.sv -----
// Monitor core: limits, counters, latches and the registered result beat.
// Depends on sfm_pkg and sfm_rsp_if.
`default_nettype none

module sfm_core
   import sfm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire sfm_stage_type          stage,
   output logic                        stage_take,
   sfm_rsp_if.source                   rsp
);

   logic [7:0]  silence_limit_ff;
   logic [15:0] warning_limit_ff;
   logic [7:0]  silence_count_ff, silence_count_in;
   logic [15:0] warning_count_ff, warning_count_in;
   logic        can_loss_ff, can_loss_in;
   logic        wdi_ff, wdi_in;
   logic        wdg_fail_ff, wdg_fail_in;
   logic        out_valid_ff, out_valid_in;
   sfm_rsp_type out_ff, out_in;

   logic [7:0]  silence_base;
   logic [7:0]  base_mask;
   logic        busoff;
   logic        warning;
   logic        can_down;
   logic        critical;
   logic        feed_ok;
   sfm_req_type d;

   assign d          = stage.data;
   assign stage_take = stage.valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      busoff  = d.can_state == CAN_ST_BUSOFF;
      warning = d.can_state == CAN_ST_WARNING;

      // clear on reception, then saturating increment
      silence_base     = d.can_rx_seen ? 8'd0 : silence_count_ff;
      silence_count_in = (silence_base == 8'hFF) ? silence_base : silence_base + 8'd1;

      if (warning) begin
         warning_count_in = (warning_count_ff == 16'hFFFF) ? warning_count_ff
                                                           : warning_count_ff + 16'd1;
      end else begin
         warning_count_in = '0;
      end

      can_down = busoff || can_loss_ff
              || (silence_count_in >= silence_limit_ff)
              || (warning && (warning_count_in >= warning_limit_ff));
      can_loss_in = can_down;

      base_mask                 = '0;
      base_mask[FM_OVERCURRENT] = d.overcurrent;
      base_mask[FM_OVERTEMP]    = d.overtemp;
      base_mask[FM_DIRECTION]   = d.dir_err;
      base_mask[FM_STALL]       = d.stall_err;
      base_mask[FM_BATTERY]     = d.batt_err;
      base_mask[FM_SELFTEST]    = d.self_test_failed;
      base_mask[FM_CAN]         = can_down;

      critical = (base_mask & FM_CRITICAL) != 8'd0;
      feed_ok  = !critical && !d.vehicle_shutdown && !d.self_test_failed && !busoff;

      wdi_in      = feed_ok ? !wdi_ff : wdi_ff;
      wdg_fail_in = !feed_ok;

      out_in.flt_bits              = base_mask;
      out_in.flt_bits[FM_WATCHDOG] = !feed_ok;
      if (critical || d.estop) begin
         out_in.status_code = STATUS_FAULT;
      end else if (base_mask != 8'd0) begin
         out_in.status_code = STATUS_DEGRADED;
      end else begin
         out_in.status_code = STATUS_OK;
      end
      out_in.motor_disable   = can_down;
      out_in.wdi_level       = wdi_in;
      out_in.wdg_fail_report = !feed_ok && !wdg_fail_ff;

      out_valid_in = out_valid_ff;
      if (stage_take) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_limit_ff <= SILENCE_LIMIT_RST;
         warning_limit_ff <= WARNING_LIMIT_RST;
         silence_count_ff <= '0;
         warning_count_ff <= '0;
         can_loss_ff      <= 1'b0;
         wdi_ff           <= 1'b0;
         wdg_fail_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SILENCE_LIMIT: silence_limit_ff <= csr_wdata[7:0];
               CSR_WARNING_LIMIT: warning_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (stage_take) begin
            silence_count_ff <= silence_count_in;
            warning_count_ff <= warning_count_in;
            can_loss_ff      <= can_loss_in;
            wdi_ff           <= wdi_in;
            wdg_fail_ff      <= wdg_fail_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.flt_bits        = out_ff.flt_bits;
   assign rsp.status_code     = out_ff.status_code;
   assign rsp.motor_disable   = out_ff.motor_disable;
   assign rsp.wdi_level       = out_ff.wdi_level;
   assign rsp.wdg_fail_report = out_ff.wdg_fail_report;

endmodule : sfm_core

`default_nettype wire

// ----- sv/safety_fault_monitor_top.sv -----
// Top level of the safety fault monitor: input register plus monitor core.
// Depends on sfm_pkg, sfm_if.sv, sfm_in_reg and sfm_core.
//
//   Channel   Dir  Handshake          Beat content
//   req_chan  in   valid/ready        one 10 ms tick: fault flags, e-stop, shutdown,
//                                     self-test, CAN error state, CAN rx flag
//   rsp_chan  out  valid/ready        fault mask, status, motor disable, WDI level,
//                                     watchdog failure pulse
//   csr_*     in   write enable only  index 0 silence limit, 1 warning limit
//
// Each tick passes from acceptance through the input register, then through
// the counter/latch logic into the result register.
// One beat is accepted per cycle while the response side keeps taking them.
// Reset (synchronous, active high) clears counters, latches and the WDI level
// and restores the limits to 20 and 50 ticks.
// A stalled response holds its register; the input register then takes at
// most one more beat, and req_chan.ready stays low while it is full.
`default_nettype none

module safety_fault_monitor_top
   import sfm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   sfm_req_if.sink                     req_chan,
   sfm_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   sfm_stage_type stage;
   logic          stage_take;

   // capture the tick beat
   sfm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .stage      (stage),
      .stage_take (stage_take)
   );

   // update counters and latches, register the result beat
   sfm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stage      (stage),
      .stage_take (stage_take),
      .rsp        (rsp_chan)
   );

endmodule : safety_fault_monitor_top

`default_nettype wire

// ----- bench/safety_fault_monitor_top_test.sv -----
// Self-checking bench for safety_fault_monitor_top: drives tick beats, predicts every
// result beat and compares it field by field. Depends on sfm_pkg and the sfm_if.sv channels.
`timescale 1ns / 1ps

module safety_fault_monitor_top_test;
   import sfm_pkg::*;

   // CAN state codes that the package leaves unnamed
   localparam logic [1:0] CAN_ST_ACTIVE = 2'd0;
   localparam logic [1:0] CAN_ST_UNUSED = 2'd3;

   // Far above the slowest legal run (about 1300 beats)
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct {
      sfm_req_type tick;
      bit          typed;
      sfm_rsp_type rsp;
   } tick_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sfm_req_if req_chan ();
   sfm_rsp_if rsp_chan ();

   safety_fault_monitor_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted monitor state, kept apart from the block
   logic [7:0]  quiet_limit;
   logic [15:0] warn_limit;
   logic [7:0]  quiet_ticks;
   logic [15:0] warn_ticks;
   logic        can_lost;
   logic        wdi_pin;
   logic        starved;

   sfm_rsp_type  status_due[$];   // result beats still owed by the block
   tick_row_type tick_table[$];   // directed stimulus
   int unsigned  mismatches   = 0;
   int unsigned  ticks_taken  = 0;
   int unsigned  cycle_count  = 0;
   bit           calm         = 1'b0;   // no idling on either side while set
   bit           cur_typed    = 1'b0;
   sfm_rsp_type  cur_rsp      = '0;

   // Advance the predicted monitor by one tick and return the result it owes.
   function automatic sfm_rsp_type monitor_tick(input sfm_req_type t);
      sfm_rsp_type r;
      logic [7:0]  mask;
      logic        can_down;
      logic        feed;
      mask = '0;
      mask[FM_OVERCURRENT] = t.overcurrent;
      mask[FM_OVERTEMP]    = t.overtemp;
      mask[FM_DIRECTION]   = t.dir_err;
      mask[FM_STALL]       = t.stall_err;
      mask[FM_BATTERY]     = t.batt_err;
      mask[FM_SELFTEST]    = t.self_test_failed;
      can_down = (t.can_state == CAN_ST_BUSOFF);
      // a received frame clears silence before this tick counts
      if (t.can_rx_seen) quiet_ticks = '0;
      if (quiet_ticks != 8'hFF) quiet_ticks = quiet_ticks + 8'd1;
      if (quiet_ticks >= quiet_limit) can_down = 1'b1;
      // only the warning code counts; active, bus-off and the unused code clear it
      if (t.can_state == CAN_ST_WARNING) begin
         if (warn_ticks != 16'hFFFF) warn_ticks = warn_ticks + 16'd1;
         if (warn_ticks >= warn_limit) can_down = 1'b1;
      end else begin
         warn_ticks = '0;
      end
      can_lost = can_lost | can_down;
      can_down = can_lost;
      mask[FM_CAN] = can_down;
      // watchdog bit is added after classification
      if ((mask & FM_CRITICAL) != 8'h00 || t.estop) begin
         r.status_code = STATUS_FAULT;
      end else if (mask != 8'h00) begin
         r.status_code = STATUS_DEGRADED;
      end else begin
         r.status_code = STATUS_OK;
      end
      feed = (mask & FM_CRITICAL) == 8'h00 && !t.vehicle_shutdown && !t.self_test_failed &&
             t.can_state != CAN_ST_BUSOFF;
      r.wdg_fail_report = 1'b0;
      if (feed) begin
         wdi_pin = ~wdi_pin;
         starved = 1'b0;
      end else begin
         r.wdg_fail_report = ~starved;
         starved = 1'b1;
         mask[FM_WATCHDOG] = 1'b1;
      end
      r.flt_bits      = mask;
      r.motor_disable = can_down;
      r.wdi_level     = wdi_pin;
      return r;
   endfunction

   // Random tick. With guard set, turn bus-off into error-active and hold silence and
   // warning runs just short of their limits so the loss latch stays clear and the rest stays reachable.
   function automatic sfm_req_type random_tick(input bit guard, input int unsigned rx_pct);
      sfm_req_type t;
      t.overcurrent      = ($urandom_range(0, 9) == 0);
      t.overtemp         = ($urandom_range(0, 9) == 0);
      t.dir_err          = ($urandom_range(0, 9) == 0);
      t.stall_err        = ($urandom_range(0, 5) == 0);
      t.batt_err         = ($urandom_range(0, 5) == 0);
      t.self_test_failed = ($urandom_range(0, 5) == 0);
      t.estop            = ($urandom_range(0, 5) == 0);
      t.vehicle_shutdown = ($urandom_range(0, 5) == 0);
      t.can_state        = 2'($urandom_range(0, 3));
      t.can_rx_seen      = ($urandom_range(0, 99) < rx_pct);
      if (guard) begin
         if (int'(quiet_ticks) + 1 >= int'(quiet_limit)) t.can_rx_seen = 1'b1;
         if (t.can_state == CAN_ST_BUSOFF) t.can_state = CAN_ST_ACTIVE;
         if (t.can_state == CAN_ST_WARNING && int'(warn_ticks) + 1 >= int'(warn_limit))
            t.can_state = $urandom_range(0, 1) ? CAN_ST_ACTIVE : CAN_ST_UNUSED;
      end
      return t;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sample both channels and the CSR port at the rising edge.
   always @(posedge clock) begin : scoreboard
      sfm_req_type beat;
      sfm_rsp_type want;
      sfm_rsp_type got;
      cycle_count++;
      if (reset) begin
         quiet_limit = SILENCE_LIMIT_RST;
         warn_limit  = WARNING_LIMIT_RST;
         quiet_ticks = '0;
         warn_ticks  = '0;
         can_lost    = 1'b0;
         wdi_pin     = 1'b0;
         starved     = 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SILENCE_LIMIT: quiet_limit = csr_wdata[7:0];
               CSR_WARNING_LIMIT: warn_limit  = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            beat = {req_chan.overcurrent, req_chan.overtemp, req_chan.dir_err,
                    req_chan.stall_err, req_chan.batt_err, req_chan.self_test_failed,
                    req_chan.estop, req_chan.vehicle_shutdown, req_chan.can_state,
                    req_chan.can_rx_seen};
            want = monitor_tick(beat);
            // a typed row overrides the prediction, the state still advances
            status_due.push_back(cur_typed ? cur_rsp : want);
            ticks_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.flt_bits, rsp_chan.status_code, rsp_chan.motor_disable,
                   rsp_chan.wdi_level, rsp_chan.wdg_fail_report};
            if (status_due.size() == 0) begin
               $display("%0t: result beat with nothing expected, got %0h", $time, got);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("flt_bits", want.flt_bits, got.flt_bits);
               check_field("status_code", 8'(want.status_code), 8'(got.status_code));
               check_field("motor_disable", 8'(want.motor_disable), 8'(got.motor_disable));
               check_field("wdi_level", 8'(want.wdi_level), 8'(got.wdi_level));
               check_field("wdg_fail_report", 8'(want.wdg_fail_report),
                           8'(got.wdg_fail_report));
            end
         end
      end
   end

   // Result side: stall about 16 percent of the time unless calm.
   always @(negedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 16);
   end

   // Unless calm, idle at random with valid low; then present one tick beat and hold
   // it until the block takes it. Call and return at a falling edge; valid stays high on return.
   task automatic send_tick(input sfm_req_type t, input bit typed, input sfm_rsp_type rsp);
      int unsigned seen;
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      seen = ticks_taken;
      cur_typed = typed;
      cur_rsp   = rsp;
      req_chan.valid <= 1'b1;
      {req_chan.overcurrent, req_chan.overtemp, req_chan.dir_err,
       req_chan.stall_err, req_chan.batt_err, req_chan.self_test_failed,
       req_chan.estop, req_chan.vehicle_shutdown, req_chan.can_state,
       req_chan.can_rx_seen} <= t;
      do @(negedge clock); while (ticks_taken == seen);
   endtask

   // Flags are {overcurrent, overtemp, direction, stall, battery, selftest, estop, shutdown}.
   task automatic add_row(input logic [7:0] flags, input logic [1:0] can, input logic rx,
                          input bit typed, input sfm_rsp_type rsp);
      tick_row_type row;
      row.tick  = {flags, can, rx};
      row.typed = typed;
      row.rsp   = rsp;
      tick_table.push_back(row);
   endtask

   task automatic run_phase(input int unsigned count, input bit guard, input int unsigned rx_pct);
      repeat (count) send_tick(random_tick(guard, rx_pct), 1'b0, '0);
   endtask

   // Drop valid, wait out every owed beat, then let the pipeline go quiet.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write both limits on back-to-back cycles; only while the block is idle.
   task automatic set_limits(input logic [7:0] quiet, input logic [15:0] warn);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SILENCE_LIMIT;
      csr_wdata <= {8'h00, quiet};
      @(negedge clock);
      csr_index <= CSR_WARNING_LIMIT;
      csr_wdata <= warn;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      {req_chan.overcurrent, req_chan.overtemp, req_chan.dir_err,
       req_chan.stall_err, req_chan.batt_err, req_chan.self_test_failed,
       req_chan.estop, req_chan.vehicle_shutdown, req_chan.can_state,
       req_chan.can_rx_seen} = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_SILENCE_LIMIT;
      csr_wdata = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset limits (20 silent, 50 warning). Every row
      // carries a frame or a short silence, so the loss latch stays clear.
      add_row(8'b0000_0000, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'h00, STATUS_OK, 1'b0, 1'b1, 1'b0});
      // first critical fault: starve the watchdog, pulse the report once
      add_row(8'b1000_0000, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'h81, STATUS_FAULT, 1'b0, 1'b1, 1'b1});
      add_row(8'b0100_0000, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'h82, STATUS_FAULT, 1'b0, 1'b1, 1'b0});
      add_row(8'b0010_0000, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'h84, STATUS_FAULT, 1'b0, 1'b1, 1'b0});
      // stall and battery only degrade and keep feeding
      add_row(8'b0001_0000, CAN_ST_ACTIVE, 1'b1, 1'b1,
              {8'h08, STATUS_DEGRADED, 1'b0, 1'b0, 1'b0});
      add_row(8'b0000_1000, CAN_ST_ACTIVE, 1'b1, 1'b1,
              {8'h10, STATUS_DEGRADED, 1'b0, 1'b1, 1'b0});
      // self-test failure degrades but blocks feeding
      add_row(8'b0000_0100, CAN_ST_ACTIVE, 1'b1, 1'b1,
              {8'hA0, STATUS_DEGRADED, 1'b0, 1'b1, 1'b1});
      // e-stop forces FAULT without blocking feed
      add_row(8'b0000_0010, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'h00, STATUS_FAULT, 1'b0, 1'b0, 1'b0});
      // shutdown starves the watchdog; its bit alone leaves status OK
      add_row(8'b0000_0001, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'h80, STATUS_OK, 1'b0, 1'b0, 1'b1});
      add_row(8'b0000_0001, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'h80, STATUS_OK, 1'b0, 1'b0, 1'b0});
      add_row(8'b1111_1111, CAN_ST_ACTIVE, 1'b1, 1'b1, {8'hBF, STATUS_FAULT, 1'b0, 1'b0, 1'b0});
      // unused CAN code acts as error-active
      add_row(8'b0000_0000, CAN_ST_UNUSED, 1'b1, 1'b1, {8'h00, STATUS_OK, 1'b0, 1'b1, 1'b0});
      add_row(8'b0000_0000, CAN_ST_WARNING, 1'b1, 1'b1, {8'h00, STATUS_OK, 1'b0, 1'b0, 1'b0});
      add_row(8'b0000_0000, CAN_ST_WARNING, 1'b1, 1'b1, {8'h00, STATUS_OK, 1'b0, 1'b1, 1'b0});
      add_row(8'b0000_0000, CAN_ST_UNUSED, 1'b1, 1'b1, {8'h00, STATUS_OK, 1'b0, 1'b0, 1'b0});
      add_row(8'b0000_0000, CAN_ST_ACTIVE, 1'b0, 1'b1, {8'h00, STATUS_OK, 1'b0, 1'b1, 1'b0});
      add_row(8'b1000_0000, CAN_ST_ACTIVE, 1'b0, 1'b0, '0);
      add_row(8'b0000_0010, CAN_ST_WARNING, 1'b0, 1'b0, '0);
      add_row(8'b0001_1000, CAN_ST_WARNING, 1'b1, 1'b0, '0);
      add_row(8'b1111_1111, CAN_ST_UNUSED, 1'b0, 1'b0, '0);
      add_row(8'b0001_0001, CAN_ST_WARNING, 1'b0, 1'b0, '0);
      foreach (tick_table[i]) send_tick(tick_table[i].tick, tick_table[i].typed, tick_table[i].rsp);
      settle();

      // Widest limits: nothing random gets near loss.
      set_limits(8'hFF, 16'hFFFF);
      run_phase(250, 1'b1, 40);
      settle();

      // Tight limits: runs of silence and warning stop one short of loss.
      set_limits(8'd4, 16'd3);
      run_phase(300, 1'b1, 50);
      settle();

      // Tightest limits that still avoid loss, with no idling at all.
      calm = 1'b1;
      set_limits(8'd2, 16'd2);
      run_phase(200, 1'b1, 50);
      settle();
      calm = 1'b0;

      // Zero warning limit and bus-off allowed: the latch sets early and holds;
      // then a long silence drives the silence count into saturation.
      set_limits(8'hFF, 16'h0000);
      run_phase(150, 1'b0, 50);
      run_phase(270, 1'b0, 0);
      settle();

      // Lowest legal limits, then zero limits, both with the latch already set.
      set_limits(8'd1, 16'd1);
      run_phase(40, 1'b0, 50);
      settle();
      set_limits(8'd0, 16'd0);
      run_phase(30, 1'b0, 50);
      settle();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
sv/sfm_pkg.sv
sv/sfm_if.sv
sv/sfm_in_reg.sv
sv/sfm_core.sv
sv/safety_fault_monitor_top.sv
bench/safety_fault_monitor_top_test.sv
